// ===== rtl/sphv_pkg.sv =====
// Shared types, constants and tables of the UV sphere vertex generator.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package sphv_pkg;

  localparam int COUNT_BITS_DEF = 8;
  localparam int COORD_BITS_DEF = 16;

  localparam int PHASE_BITS       = 32;
  localparam int CORDIC_BITS      = 32;
  localparam int CORDIC_STEPS     = 24;
  localparam int CORDIC_PER_STAGE = 2;
  localparam int DIV_PER_STAGE    = 4;
  localparam int TRI_BITS         = 16;
  localparam int CFG_INDEX_BITS   = 1;

  localparam logic signed [CORDIC_BITS-1:0] CORDIC_GAIN_INV = 32'sd652032874;

  localparam logic [CFG_INDEX_BITS-1:0] REG_STACK_COUNT  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SECTOR_COUNT = 1'd1;

  typedef enum logic [1:0] {QUAD_0, QUAD_90, QUAD_180, QUAD_270} quad_t;

  typedef struct packed {
    logic                has_triangles;
    logic [TRI_BITS-1:0] tri_a0;
    logic [TRI_BITS-1:0] tri_a1;
    logic [TRI_BITS-1:0] tri_a2;
    logic [TRI_BITS-1:0] tri_b0;
    logic [TRI_BITS-1:0] tri_b1;
    logic [TRI_BITS-1:0] tri_b2;
    logic                index_error;
  } tri_info_t;

  function automatic logic signed [CORDIC_BITS-1:0] atan_turn(input int k);
    logic signed [CORDIC_BITS-1:0] a;
    case (k)
      0:  a = 32'sd536870912;
      1:  a = 32'sd316933406;
      2:  a = 32'sd167458907;
      3:  a = 32'sd85004756;
      4:  a = 32'sd42667331;
      5:  a = 32'sd21354465;
      6:  a = 32'sd10679838;
      7:  a = 32'sd5340245;
      8:  a = 32'sd2670163;
      9:  a = 32'sd1335087;
      10: a = 32'sd667544;
      11: a = 32'sd333772;
      12: a = 32'sd166886;
      13: a = 32'sd83443;
      14: a = 32'sd41722;
      15: a = 32'sd20861;
      16: a = 32'sd10430;
      17: a = 32'sd5215;
      18: a = 32'sd2608;
      19: a = 32'sd1304;
      20: a = 32'sd652;
      21: a = 32'sd326;
      22: a = 32'sd163;
      23: a = 32'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sphv_div.sv =====
// Pipelined restoring divider: (num << SH) / den, low 32 quotient bits.
// Depends on sphv_pkg; four quotient bits are resolved in each stage.
`default_nettype none

module sphv_div
  import sphv_pkg::*;
#(
  parameter int NB = COUNT_BITS_DEF,
  parameter int SH = 32,
  parameter int NS = (COUNT_BITS_DEF + 32 + DIV_PER_STAGE - 1) / DIV_PER_STAGE
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [NB-1:0]         num,
  input  wire logic [NB-1:0]         den,
  output logic      [PHASE_BITS-1:0] quo
);

  localparam int PW = NS * DIV_PER_STAGE;

  logic [NB-1:0]         rem [NS];
  logic [PW-1:0]         dv  [NS];
  logic [PHASE_BITS-1:0] qt  [NS];

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic [NB-1:0]         r_i, r_o;
    logic [PW-1:0]         d_i, d_o;
    logic [PHASE_BITS-1:0] q_i, q_o;

    if (g == 0) begin : g_first
      assign r_i = '0;
      assign d_i = PW'({num, {SH{1'b0}}});
      assign q_i = '0;
    end else begin : g_next
      assign r_i = rem[g-1];
      assign d_i = dv[g-1];
      assign q_i = qt[g-1];
    end

    always_comb begin : p_step
      logic [NB:0] t;
      r_o = r_i;
      d_o = d_i;
      q_o = q_i;
      for (int b = 0; b < DIV_PER_STAGE; b++) begin
        t   = {r_o, d_o[PW-1]};
        d_o = {d_o[PW-2:0], 1'b0};
        if (t >= {1'b0, den}) begin
          t   = t - {1'b0, den};
          q_o = {q_o[PHASE_BITS-2:0], 1'b1};
        end else begin
          q_o = {q_o[PHASE_BITS-2:0], 1'b0};
        end
        r_o = t[NB-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g] <= r_o;
        dv[g]  <= d_o;
        qt[g]  <= q_o;
      end
    end
  end

  assign quo = qt[NS-1];

endmodule

`default_nettype wire

// ===== rtl/sphv_cordic.sv =====
// Pipelined CORDIC giving cosine and sine of a 32-bit turn phase in Q2.30.
// Depends on sphv_pkg for the arctangent table, gain and quadrant codes.
`default_nettype none

module sphv_cordic
  import sphv_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic        [PHASE_BITS-1:0]  phase,
  output logic signed      [CORDIC_BITS-1:0] cos_val,
  output logic signed      [CORDIC_BITS-1:0] sin_val
);

  localparam int NST = CORDIC_STEPS / CORDIC_PER_STAGE;

  logic [PHASE_BITS-1:0]        pq;
  quad_t                        quad_in;
  logic [PHASE_BITS-1:0]        resid;
  quad_t                        quad0;
  logic signed [CORDIC_BITS-1:0] z0;

  assign pq      = phase + 32'h2000_0000;
  assign quad_in = quad_t'(pq[PHASE_BITS-1:PHASE_BITS-2]);
  assign resid   = phase - {pq[PHASE_BITS-1:PHASE_BITS-2], {(PHASE_BITS-2){1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      quad0 <= quad_in;
      z0    <= $signed(resid);
    end
  end

  logic signed [CORDIC_BITS-1:0] xs [NST];
  logic signed [CORDIC_BITS-1:0] ys [NST];
  logic signed [CORDIC_BITS-1:0] zs [NST];
  quad_t                         qs [NST];

  for (genvar g = 0; g < NST; g++) begin : g_stage
    logic signed [CORDIC_BITS-1:0] x_i, y_i, z_i, x_o, y_o, z_o;
    quad_t                         q_i;

    if (g == 0) begin : g_first
      assign x_i = CORDIC_GAIN_INV;
      assign y_i = '0;
      assign z_i = z0;
      assign q_i = quad0;
    end else begin : g_next
      assign x_i = xs[g-1];
      assign y_i = ys[g-1];
      assign z_i = zs[g-1];
      assign q_i = qs[g-1];
    end

    always_comb begin : p_rot
      logic signed [CORDIC_BITS-1:0] dx, dy;
      x_o = x_i;
      y_o = y_i;
      z_o = z_i;
      for (int b = 0; b < CORDIC_PER_STAGE; b++) begin
        dx = y_o >>> (g * CORDIC_PER_STAGE + b);
        dy = x_o >>> (g * CORDIC_PER_STAGE + b);
        if (z_o >= 0) begin
          x_o = x_o - dx;
          y_o = y_o + dy;
          z_o = z_o - atan_turn(g * CORDIC_PER_STAGE + b);
        end else begin
          x_o = x_o + dx;
          y_o = y_o - dy;
          z_o = z_o + atan_turn(g * CORDIC_PER_STAGE + b);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xs[g] <= x_o;
        ys[g] <= y_o;
        zs[g] <= z_o;
        qs[g] <= q_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (qs[NST-1])
        QUAD_0: begin
          cos_val <= xs[NST-1];
          sin_val <= ys[NST-1];
        end
        QUAD_90: begin
          cos_val <= -ys[NST-1];
          sin_val <= xs[NST-1];
        end
        QUAD_180: begin
          cos_val <= -xs[NST-1];
          sin_val <= -ys[NST-1];
        end
        default: begin
          cos_val <= ys[NST-1];
          sin_val <= -xs[NST-1];
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sphv_out.sv =====
// Output arithmetic: products of latitude and longitude terms, rounding,
// and conversion to the saturated coordinate format. Depends on sphv_pkg.
`default_nettype none

module sphv_out
  import sphv_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [CORDIC_BITS-1:0] cos_lat,
  input  wire logic signed [CORDIC_BITS-1:0] sin_lat,
  input  wire logic signed [CORDIC_BITS-1:0] cos_lon,
  input  wire logic signed [CORDIC_BITS-1:0] sin_lon,
  output logic signed      [COORD_BITS-1:0]  pos_x,
  output logic signed      [COORD_BITS-1:0]  pos_y,
  output logic signed      [COORD_BITS-1:0]  pos_z
);

  localparam int SH  = 30 - (COORD_BITS - 1);
  localparam int SHP = (SH > 0) ? SH : 0;
  localparam int SHN = (SH < 0) ? -SH : 0;
  localparam logic signed [35:0] RND = (36'sd1 <<< SHP) >>> 1;
  localparam logic signed [35:0] LIM = (36'sd1 <<< (COORD_BITS - 1)) - 36'sd1;

  function automatic logic signed [COORD_BITS-1:0] to_coord(input logic signed [33:0] v);
    logic signed [35:0] w;
    w = (SH > 0) ? ((36'(v) + RND) >>> SHP) : (36'(v) <<< SHN);
    if (w > LIM) w = LIM;
    if (w < -LIM) w = -LIM;
    return COORD_BITS'(w);
  endfunction

  logic signed [63:0] prod_x, prod_y;
  logic signed [33:0] z1, mul_x, mul_y, z2;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x <= 64'(cos_lat) * 64'(cos_lon);
      prod_y <= 64'(cos_lat) * 64'(sin_lon);
      z1     <= 34'(sin_lat);
      mul_x  <= 34'((prod_x + 64'sd536870912) >>> 30);
      mul_y  <= 34'((prod_y + 64'sd536870912) >>> 30);
      z2     <= z1;
      pos_x  <= to_coord(mul_x);
      pos_y  <= to_coord(mul_y);
      pos_z  <= to_coord(z2);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sphv_idx.sv =====
// Triangle index and range check logic, delayed to line up with the
// position pipeline. Depends on sphv_pkg for the result struct.
`default_nettype none

module sphv_idx
  import sphv_pkg::*;
#(
  parameter int NB    = COUNT_BITS_DEF,
  parameter int DELAY = 4
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NB-1:0] si,
  input  wire logic [NB-1:0] sj,
  input  wire logic [NB-1:0] ns,
  input  wire logic [NB-1:0] nc,
  output tri_info_t          info
);

  logic [31:0]         prod;
  logic [TRI_BITS-1:0] first, second;
  logic                err, tri_ok;
  tri_info_t           info_in;
  tri_info_t           pipe [DELAY];

  assign prod   = 32'(si) * (32'(nc) + 32'd1) + 32'(sj);
  assign first  = prod[TRI_BITS-1:0];
  assign second = first + TRI_BITS'(nc) + TRI_BITS'(1);
  assign err    = (si > ns) || (sj > nc);
  assign tri_ok = !err && (si < ns) && (sj < nc);

  always_comb begin
    info_in               = '0;
    info_in.index_error   = err;
    info_in.has_triangles = tri_ok;
    if (tri_ok) begin
      info_in.tri_a0 = first;
      info_in.tri_a1 = second;
      info_in.tri_a2 = first + TRI_BITS'(1);
      info_in.tri_b0 = second;
      info_in.tri_b1 = second + TRI_BITS'(1);
      info_in.tri_b2 = first + TRI_BITS'(1);
    end
  end

  for (genvar g = 0; g < DELAY; g++) begin : g_delay
    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) pipe[g] <= info_in;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) pipe[g] <= pipe[g-1];
      end
    end
  end

  assign info = pipe[DELAY-1];

endmodule

`default_nettype wire

// ===== rtl/uv_sphere_vertex_generator_unit.sv =====
// UV sphere vertex generator: one grid point in, one vertex with its
// quad triangle indices out. Depends on sphv_pkg and all sphv_* modules.
//
// Usage: an input beat carries stack_index and sector_index on the
// item_valid/item_ready channel; the result beat carries the position and
// triangle indices on result_valid/result_ready. stack_count and
// sector_count are written through cfg_write/cfg_index/cfg_data while no
// beat is in flight.
// The result is registered through the divider, CORDIC and output stages:
// the angle dividers resolve four quotient bits per stage, the CORDIC
// units take two rotations per stage plus entry and quadrant stages, and
// the output path takes three stages for product, rounding and saturation.
// Throughput is one beat per cycle while the receiver does not stall.
// Reset clears the pipeline valid bits and loads stack_count = 16 and
// sector_count = 32. When the receiver stalls the whole pipeline holds,
// item_ready is low while the final stage is occupied and result_ready is
// low, and nothing is lost.
`default_nettype none

module uv_sphere_vertex_generator_unit
  import sphv_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [COUNT_BITS-1:0]       cfg_data,
  input  wire logic                        item_valid,
  output logic                             item_ready,
  input  wire logic [COUNT_BITS-1:0]       stack_index,
  input  wire logic [COUNT_BITS-1:0]       sector_index,
  output logic                             result_valid,
  input  wire logic                        result_ready,
  output logic signed [COORD_BITS-1:0]     pos_x,
  output logic signed [COORD_BITS-1:0]     pos_y,
  output logic signed [COORD_BITS-1:0]     pos_z,
  output logic                             has_triangles,
  output logic [TRI_BITS-1:0]              tri_a0,
  output logic [TRI_BITS-1:0]              tri_a1,
  output logic [TRI_BITS-1:0]              tri_a2,
  output logic [TRI_BITS-1:0]              tri_b0,
  output logic [TRI_BITS-1:0]              tri_b1,
  output logic [TRI_BITS-1:0]              tri_b2,
  output logic                             index_error
);

  localparam int DIV_ST = (COUNT_BITS + 32 + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
  localparam int COR_ST = CORDIC_STEPS / CORDIC_PER_STAGE + 2;
  localparam int LAT    = DIV_ST + COR_ST + 3;

  logic [COUNT_BITS-1:0] stack_count, sector_count;
  logic [COUNT_BITS-1:0] ns, nc;
  logic                  en;
  logic [LAT-1:0]        vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count  <= COUNT_BITS'(16);
      sector_count <= COUNT_BITS'(32);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STACK_COUNT:  stack_count  <= cfg_data;
        REG_SECTOR_COUNT: sector_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ns = (stack_count < COUNT_BITS'(2)) ? COUNT_BITS'(2) : stack_count;
  assign nc = (sector_count < COUNT_BITS'(3)) ? COUNT_BITS'(3) : sector_count;

  assign en           = !vld[LAT-1] || result_ready;
  assign item_ready   = en;
  assign result_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], item_valid};
    end
  end

  logic [PHASE_BITS-1:0] quo_lat, quo_lon, lat_phase;

  sphv_div #(.NB(COUNT_BITS), .SH(31), .NS(DIV_ST)) u_div_lat (
    .clk(clk), .en(en), .num(stack_index), .den(ns), .quo(quo_lat)
  );

  sphv_div #(.NB(COUNT_BITS), .SH(32), .NS(DIV_ST)) u_div_lon (
    .clk(clk), .en(en), .num(sector_index), .den(nc), .quo(quo_lon)
  );

  assign lat_phase = 32'h4000_0000 - quo_lat;

  logic signed [CORDIC_BITS-1:0] cos_lat, sin_lat, cos_lon, sin_lon;

  sphv_cordic u_cordic_lat (
    .clk(clk), .en(en), .phase(lat_phase), .cos_val(cos_lat), .sin_val(sin_lat)
  );

  sphv_cordic u_cordic_lon (
    .clk(clk), .en(en), .phase(quo_lon), .cos_val(cos_lon), .sin_val(sin_lon)
  );

  sphv_out #(.COORD_BITS(COORD_BITS)) u_out (
    .clk(clk), .en(en),
    .cos_lat(cos_lat), .sin_lat(sin_lat), .cos_lon(cos_lon), .sin_lon(sin_lon),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z)
  );

  tri_info_t info;

  sphv_idx #(.NB(COUNT_BITS), .DELAY(LAT)) u_idx (
    .clk(clk), .en(en), .si(stack_index), .sj(sector_index),
    .ns(ns), .nc(nc), .info(info)
  );

  assign has_triangles = info.has_triangles;
  assign tri_a0        = info.tri_a0;
  assign tri_a1        = info.tri_a1;
  assign tri_a2        = info.tri_a2;
  assign tri_b0        = info.tri_b0;
  assign tri_b1        = info.tri_b1;
  assign tri_b2        = info.tri_b2;
  assign index_error   = info.index_error;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the UV sphere vertex generator: drives grid points, predicts
// each vertex with a local CORDIC/fixed-point model and checks every beat.
// Depends on sphv_pkg and uv_sphere_vertex_generator_unit.
`timescale 1ns / 1ps

module tb_top;
  import sphv_pkg::*;

  typedef struct {
    logic signed [15:0] x, y, z;
    logic               tri_ok;
    logic [15:0]        a0, a1, a2, b0, b1, b2;
    logic               err;
  } vertex_t;

  class vertex_scoreboard;
    vertex_t pending[$];
    int      errors;
    logic [7:0] stacks, sectors;

    function new();
      errors = 0;
      stacks = 8'd16;
      sectors = 8'd32;
    endfunction

    function longint fshift(longint v, int k);
      return v >>> k;
    endfunction

    function void rotate(logic [31:0] p, output longint c, output longint s);
      logic [1:0] q;
      logic [31:0] rr;
      longint x, y, z, dx, dy, t;
      q = 2'((p + 32'h2000_0000) >> 30);
      rr = p - {q, 30'd0};
      z = longint'($signed(rr));
      x = 652032874;
      y = 0;
      for (int k = 0; k < 24; k++) begin
        dx = fshift(y, k);
        dy = fshift(x, k);
        t = longint'(atan_turn(k));
        if (z >= 0) begin
          x -= dx; y += dy; z -= t;
        end else begin
          x += dx; y -= dy; z += t;
        end
      end
      case (quad_t'(q))
        QUAD_0:   begin c = x;  s = y;  end
        QUAD_90:  begin c = -y; s = x;  end
        QUAD_180: begin c = -x; s = -y; end
        default:  begin c = y;  s = -x; end
      endcase
    endfunction

    function logic signed [15:0] to_q15(longint v);
      v = (v + (64'sd1 <<< 14)) >>> 15;
      if (v > 32767) v = 32767;
      if (v < -32767) v = -32767;
      return 16'(v);
    endfunction

    function longint mulq(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function void note_point(logic [7:0] i, logic [7:0] j);
      vertex_t e;
      longint ns, nc, cl, sl, co, so;
      logic [63:0] first, second;
      logic [31:0] latp, lonp;
      ns = (stacks < 2) ? 2 : stacks;
      nc = (sectors < 3) ? 3 : sectors;
      latp = 32'(64'h4000_0000 - ((longint'(i) << 31) / ns));
      lonp = 32'((longint'(j) << 32) / nc);
      rotate(latp, cl, sl);
      rotate(lonp, co, so);
      e.x = to_q15(mulq(cl, co));
      e.y = to_q15(mulq(cl, so));
      e.z = to_q15(sl);
      e.err = (i > ns) || (j > nc);
      e.tri_ok = !e.err && i < ns && j < nc;
      first = i * (nc + 1) + j;
      second = first + nc + 1;
      e.a0 = e.tri_ok ? 16'(first) : '0;
      e.a1 = e.tri_ok ? 16'(second) : '0;
      e.a2 = e.tri_ok ? 16'(first + 1) : '0;
      e.b0 = e.a1;
      e.b1 = e.tri_ok ? 16'(second + 1) : '0;
      e.b2 = e.a2;
      pending.push_back(e);
    endfunction

    function void report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endfunction

    function void check_vertex(vertex_t g);
      vertex_t e;
      if (pending.size() == 0) begin
        report("result beat with no point outstanding", 1, 0);
        return;
      end
      e = pending.pop_front();
      if (g.x !== e.x) report("pos_x", g.x, e.x);
      if (g.y !== e.y) report("pos_y", g.y, e.y);
      if (g.z !== e.z) report("pos_z", g.z, e.z);
      if (g.tri_ok !== e.tri_ok) report("has_triangles", g.tri_ok, e.tri_ok);
      if (g.a0 !== e.a0) report("tri_a0", g.a0, e.a0);
      if (g.a1 !== e.a1) report("tri_a1", g.a1, e.a1);
      if (g.a2 !== e.a2) report("tri_a2", g.a2, e.a2);
      if (g.b0 !== e.b0) report("tri_b0", g.b0, e.b0);
      if (g.b1 !== e.b1) report("tri_b1", g.b1, e.b1);
      if (g.b2 !== e.b2) report("tri_b2", g.b2, e.b2);
      if (g.err !== e.err) report("index_error", g.err, e.err);
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_write = 0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_STACK_COUNT;
  logic [7:0] cfg_data = 0;
  logic item_valid = 0, item_ready;
  logic [7:0] stack_index = 0, sector_index = 0;
  logic result_valid, result_ready = 0;
  logic signed [15:0] pos_x, pos_y, pos_z;
  logic has_triangles, index_error;
  logic [15:0] tri_a0, tri_a1, tri_a2, tri_b0, tri_b1, tri_b2;

  int send_idle = 0, recv_stall = 0;
  bit hold_off = 0;
  longint cycles = 0;
  vertex_scoreboard sb = new();

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  uv_sphere_vertex_generator_unit dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2_000_000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready)
      sb.check_vertex('{pos_x, pos_y, pos_z, has_triangles, tri_a0, tri_a1, tri_a2,
                        tri_b0, tri_b1, tri_b2, index_error});
    result_ready <= !hold_off && ($urandom_range(99) >= recv_stall);
  end

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [7:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 0;
    if (idx == REG_STACK_COUNT) sb.stacks = val;
    else sb.sectors = val;
    @(posedge clk);
  endtask

  task automatic send_point(logic [7:0] i, logic [7:0] j);
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 0;
      @(posedge clk);
    end
    item_valid <= 1;
    stack_index <= i;
    sector_index <= j;
    do @(posedge clk); while (!item_ready);
    sb.note_point(i, j);
  endtask

  task automatic drain();
    item_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_points(int n);
    int ns, nc;
    logic [7:0] i, j;
    ns = (sb.stacks < 2) ? 2 : sb.stacks;
    nc = (sb.sectors < 3) ? 3 : sb.sectors;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) < 8) begin
        i = 8'($urandom_range(ns));
        j = 8'($urandom_range(nc));
      end else begin
        i = 8'($urandom);
        j = 8'($urandom);
      end
      send_point(i, j);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_point(0, 0);
    send_point(16, 32);
    send_point(8, 0);
    send_point(8, 8);
    send_point(15, 31);
    send_point(17, 0);
    send_point(0, 33);
    send_point(255, 255);
    send_point(8'haa, 8'h55);
    send_point(8'h55, 8'haa);
    send_point(16, 5);
    send_point(3, 32);
    drain();
    write_reg(REG_STACK_COUNT, 0);
    write_reg(REG_SECTOR_COUNT, 1);
    send_point(1, 2);
    send_point(2, 3);
    send_point(3, 4);
    send_point(0, 0);
    drain();
    write_reg(REG_STACK_COUNT, 255);
    write_reg(REG_SECTOR_COUNT, 255);
    send_point(254, 254);
    send_point(255, 255);
    send_point(128, 64);
    drain();

    random_points(300);
    send_idle = 86;
    random_points(200);
    drain();
    write_reg(REG_STACK_COUNT, 2);
    write_reg(REG_SECTOR_COUNT, 3);
    send_idle = 0; recv_stall = 86;
    random_points(250);
    send_idle = 28; recv_stall = 28;
    random_points(200);
    drain();
    write_reg(REG_STACK_COUNT, 8'($urandom_range(2, 255)));
    write_reg(REG_SECTOR_COUNT, 8'($urandom_range(3, 255)));
    send_idle = 0; recv_stall = 0;
    fork
      begin
        hold_off = 1;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end
      random_points(150);
    join
    drain();
    write_reg(REG_STACK_COUNT, 8'($urandom));
    write_reg(REG_SECTOR_COUNT, 8'($urandom));
    random_points(300);
    send_idle = 86; recv_stall = 86;
    random_points(100);
    send_idle = 0; recv_stall = 0;
    random_points(200);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
